>>> sv/qoid_pkg.sv
`default_nettype none

package qoid_pkg;

	localparam int INDEX_ENTRIES = 64;
	localparam int COL_W         = 15;
	localparam int PIX_W         = 30;
	localparam int MARK_LEN      = 8;
	localparam int IN_TDATA_W    = 8;
	localparam int OUT_TDATA_W   = 40;

	// Op class decoded from the first byte of a chunk.
	localparam logic [2:0] CLS_RGB   = 3'd0;
	localparam logic [2:0] CLS_RGBA  = 3'd1;
	localparam logic [2:0] CLS_INDEX = 3'd2;
	localparam logic [2:0] CLS_DIFF  = 3'd3;
	localparam logic [2:0] CLS_LUMA  = 3'd4;
	localparam logic [2:0] CLS_RUN   = 3'd5;

	localparam logic [7:0] TAG_RGB  = 8'hFE;
	localparam logic [7:0] TAG_RGBA = 8'hFF;
	localparam logic [1:0] TAG2_INDEX = 2'b00;
	localparam logic [1:0] TAG2_DIFF  = 2'b01;
	localparam logic [1:0] TAG2_LUMA  = 2'b10;

	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_MARK_OK = 2'd1;
	localparam logic [1:0] KIND_MARK_BAD = 2'd2;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pix_t;

	localparam pix_t PIX_RESET = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

	typedef struct packed {
		logic       start;
		logic [2:0] cls;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		pix_t       pix;
		logic       row_end;
		logic       image_end;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

>>> sv/qoid_front.sv
`default_nettype none

module qoid_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          in_start,
	input  wire logic [7:0]    in_data,
	output logic               item_valid,
	input  wire logic          item_ready,
	output qoid_pkg::item_t    item
);
	import qoid_pkg::*;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic [2:0] cls;
	logic       push;
	logic       pop;

	// classify the chunk tag
	always_comb begin
		priority if (in_data == TAG_RGB) begin
			cls = CLS_RGB;
		end else if (in_data == TAG_RGBA) begin
			cls = CLS_RGBA;
		end else if (in_data[7:6] == TAG2_INDEX) begin
			cls = CLS_INDEX;
		end else if (in_data[7:6] == TAG2_DIFF) begin
			cls = CLS_DIFF;
		end else if (in_data[7:6] == TAG2_LUMA) begin
			cls = CLS_LUMA;
		end else begin
			cls = CLS_RUN;
		end
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = ent_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{start: in_start, cls: cls, data: in_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/qoid_back.sv
`default_nettype none

module qoid_back #(
	parameter int INDEX_ENTRIES = qoid_pkg::INDEX_ENTRIES
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_ready,
	input  wire qoid_pkg::item_t          item,
	input  wire logic [qoid_pkg::COL_W-1:0] width,
	input  wire logic [qoid_pkg::PIX_W-1:0] pixels,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output qoid_pkg::result_t             res
);
	import qoid_pkg::*;

	localparam int IDX_W = $clog2(INDEX_ENTRIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_IDX  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_RGB  = 2'd1;
	localparam logic [1:0] PEND_RGBA = 2'd2;
	localparam logic [1:0] PEND_LUMA = 2'd3;

	localparam logic [3:0] MARK_LAST = 4'(MARK_LEN - 1);

	logic [1:0]       state_q, nxt_state;
	pix_t             cur_q, nxt_cur;
	logic [1:0]       pend_q, nxt_pend;
	logic [2:0]       pcnt_q, nxt_pcnt;
	logic [5:0]       luma_q, nxt_luma;
	logic [5:0]       left_q, nxt_left;
	logic [COL_W-1:0] col_q, nxt_col;
	logic [PIX_W-1:0] done_q, nxt_done;
	logic [3:0]       mcnt_q, nxt_mcnt;
	logic             mbad_q, nxt_mbad;

	pix_t                     mem_q [INDEX_ENTRIES];
	logic [INDEX_ENTRIES-1:0] vld_q;
	pix_t                     rd_data_q;
	logic                     rd_vld_q;

	logic             out_free, take, in_image;
	logic             clear_vld, rd_en, wr_en, emit_pix, emit_stat, res_last;
	logic [1:0]       stat_kind;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [12:0]      hsum;
	logic [COL_W-1:0] col_inc;
	logic [PIX_W-1:0] done_inc;
	logic             pix_re, pix_ie;
	logic [1:0]       pos;
	logic [7:0]       dg;
	pix_t             p_chan, p_luma, p_diff;
	logic [7:0]       mark_exp;

	assign out_free   = !res_valid || res_ready;
	assign item_ready = (state_q == ST_IDLE) && out_free;
	assign take       = item_valid && item_ready;
	assign in_image   = done_q < pixels;

	assign col_inc  = col_q + 1'b1;
	assign done_inc = done_q + 1'b1;
	assign pix_re   = (col_inc == width);
	assign pix_ie   = (done_inc == pixels);

	// operand byte for RGB/RGBA: channel by position r,g,b,a
	assign pos = ((pend_q == PEND_RGB) ? 2'd3 : 2'd0) - pcnt_q[1:0];
	always_comb begin
		p_chan = cur_q;
		unique case (pos)
			2'd0: p_chan.r = item.data;
			2'd1: p_chan.g = item.data;
			2'd2: p_chan.b = item.data;
			2'd3: p_chan.a = item.data;
			default: p_chan = cur_q;
		endcase
	end

	assign dg       = {2'b00, luma_q} - 8'd32;
	assign p_luma.r = cur_q.r + dg + {4'b0000, item.data[7:4]} - 8'd8;
	assign p_luma.g = cur_q.g + dg;
	assign p_luma.b = cur_q.b + dg + {4'b0000, item.data[3:0]} - 8'd8;
	assign p_luma.a = cur_q.a;

	assign p_diff.r = cur_q.r + {6'b0, item.data[5:4]} - 8'd2;
	assign p_diff.g = cur_q.g + {6'b0, item.data[3:2]} - 8'd2;
	assign p_diff.b = cur_q.b + {6'b0, item.data[1:0]} - 8'd2;
	assign p_diff.a = cur_q.a;

	assign mark_exp = (mcnt_q == MARK_LAST) ? 8'd1 : 8'd0;

	always_comb begin
		nxt_state = state_q;
		nxt_cur   = cur_q;
		nxt_pend  = pend_q;
		nxt_pcnt  = pcnt_q;
		nxt_luma  = luma_q;
		nxt_left  = left_q;
		nxt_col   = col_q;
		nxt_done  = done_q;
		nxt_mcnt  = mcnt_q;
		nxt_mbad  = mbad_q;
		clear_vld = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		emit_pix  = 1'b0;
		emit_stat = 1'b0;
		res_last  = 1'b0;
		stat_kind = KIND_MARK_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (item.start) begin
						nxt_cur   = PIX_RESET;
						nxt_pend  = PEND_NONE;
						nxt_pcnt  = 3'd0;
						nxt_luma  = 6'd0;
						nxt_col   = '0;
						nxt_done  = '0;
						nxt_mcnt  = 4'd0;
						nxt_mbad  = 1'b0;
						clear_vld = 1'b1;
					end else if (in_image) begin
						priority if (pend_q == PEND_RGB || pend_q == PEND_RGBA) begin
							nxt_cur  = p_chan;
							nxt_pcnt = pcnt_q - 3'd1;
							if (pcnt_q == 3'd1) begin
								nxt_pend = PEND_NONE;
								wr_en    = 1'b1;
								emit_pix = 1'b1;
								res_last = 1'b1;
							end
						end else if (pend_q == PEND_LUMA) begin
							nxt_cur  = p_luma;
							nxt_pend = PEND_NONE;
							nxt_pcnt = 3'd0;
							wr_en    = 1'b1;
							emit_pix = 1'b1;
							res_last = 1'b1;
						end else begin
							unique case (item.cls)
								CLS_RGB: begin
									nxt_pend = PEND_RGB;
									nxt_pcnt = 3'd3;
								end
								CLS_RGBA: begin
									nxt_pend = PEND_RGBA;
									nxt_pcnt = 3'd4;
								end
								CLS_INDEX: begin
									rd_en     = 1'b1;
									nxt_state = ST_IDX;
								end
								CLS_DIFF: begin
									nxt_cur  = p_diff;
									wr_en    = 1'b1;
									emit_pix = 1'b1;
									res_last = 1'b1;
								end
								CLS_LUMA: begin
									nxt_pend = PEND_LUMA;
									nxt_pcnt = 3'd1;
									nxt_luma = item.data[5:0];
								end
								CLS_RUN: begin
									wr_en    = 1'b1;
									emit_pix = 1'b1;
									res_last = (item.data[5:0] == 6'd0) || pix_ie;
									if (!res_last) begin
										nxt_left  = item.data[5:0] - 6'd1;
										nxt_state = ST_RUN;
									end
								end
								default: ;
							endcase
						end
					end else if (mcnt_q < 4'(MARK_LEN)) begin
						nxt_mcnt = mcnt_q + 4'd1;
						nxt_mbad = mbad_q || (item.data != mark_exp);
						if (mcnt_q == MARK_LAST) begin
							emit_stat = 1'b1;
							res_last  = 1'b1;
							stat_kind = nxt_mbad ? KIND_MARK_BAD : KIND_MARK_OK;
						end
					end
				end
			end
			ST_IDX: begin
				if (out_free) begin
					nxt_cur   = rd_vld_q ? rd_data_q : '0;
					wr_en     = 1'b1;
					emit_pix  = 1'b1;
					res_last  = 1'b1;
					nxt_state = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (out_free) begin
					emit_pix = 1'b1;
					res_last = (left_q == 6'd0) || pix_ie;
					nxt_left = left_q - 6'd1;
					if (res_last) nxt_state = ST_IDLE;
				end
			end
			default: nxt_state = ST_IDLE;
		endcase
		if (emit_pix) begin
			nxt_col  = pix_re ? '0 : col_inc;
			nxt_done = done_inc;
		end
	end

	// hash of the pixel being stored: 3r + 5g + 7b + 11a
	assign hsum = 13'(nxt_cur.r) * 13'd3 + 13'(nxt_cur.g) * 13'd5
	            + 13'(nxt_cur.b) * 13'd7 + 13'(nxt_cur.a) * 13'd11;
	assign wr_addr = hsum[IDX_W-1:0];
	assign rd_addr = IDX_W'(item.data[5:0]);

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= nxt_cur;
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_pix || emit_stat) begin
			res.kind      <= emit_pix ? KIND_PIXEL : stat_kind;
			res.pix       <= emit_pix ? nxt_cur : '0;
			res.row_end   <= emit_pix && pix_re;
			res.image_end <= emit_pix && pix_ie;
			res.last      <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= PIX_RESET;
			pend_q    <= PEND_NONE;
			pcnt_q    <= 3'd0;
			luma_q    <= 6'd0;
			left_q    <= 6'd0;
			col_q     <= '0;
			done_q    <= '0;
			mcnt_q    <= 4'd0;
			mbad_q    <= 1'b0;
			vld_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q <= nxt_state;
			cur_q   <= nxt_cur;
			pend_q  <= nxt_pend;
			pcnt_q  <= nxt_pcnt;
			luma_q  <= nxt_luma;
			left_q  <= nxt_left;
			col_q   <= nxt_col;
			done_q  <= nxt_done;
			mcnt_q  <= nxt_mcnt;
			mbad_q  <= nxt_mbad;
			if (clear_vld) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (emit_pix || emit_stat) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/qoi_image_decoder_core.sv
// QOI chunk-stream decoder.
// Input stream (s_*): one transaction per byte of the chunk stream that follows the
// 14-byte header. s_tuser = 1 starts a new image (clears the color index, sets the
// current pixel to 0,0,0,255, zeroes the counters); s_tdata is then ignored.
// Output stream (m_*): one transaction per decoded pixel, or one status after the
// eight end-marker bytes. m_tlast marks the final result caused by one input byte.
// Config channel (cfg_*): index 0 = image_width, index 1 = image_pixels; write only
// while the block is idle. cfg_ready is always high.
// Flow: a byte is taken into a two-entry queue; the back end executes it from the
// queue head and the result is registered onto m_* (an index op first passes the
// index memory's registered read). The back end takes one byte per cycle while
// m_tready is high, but takes no new byte during an index op or a run until its pixels
// are out; it issues at most one result per cycle.
// Reset: all control state clears, image_width and image_pixels return to 1, and
// the index valid bits clear at once, so no clearing pass follows.
// Stall: when m_tready is low the result register holds, the back end stops, and
// the queue keeps taking bytes until both entries are full.
`default_nettype none

module qoi_image_decoder_core #(
	parameter int INDEX_ENTRIES = qoid_pkg::INDEX_ENTRIES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [qoid_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
	input  wire logic                              s_tuser,   // [0] command
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [32] row_end,
	// [33] image_end, [39:34] zero
	output logic [qoid_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic [1:0]                             m_tuser,   // [1:0] kind
	output logic                                   m_tlast,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic                              cfg_index,
	input  wire logic [qoid_pkg::PIX_W-1:0]        cfg_data
);
	import qoid_pkg::*;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_PIXELS = 1'b1;

	logic [COL_W-1:0] width_q;
	logic [PIX_W-1:0] pixels_q;
	logic             item_valid;
	logic             item_ready;
	item_t            item;
	result_t          res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= COL_W'(1);
			pixels_q <= PIX_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[COL_W-1:0];
				CFG_PIXELS: pixels_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and classify bytes into the queue
	qoid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_start   (s_tuser),
		.in_data    (s_tdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// back: execute ops, hold the color index, drive the result register
	qoid_back #(
		.INDEX_ENTRIES (INDEX_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.width      (width_q),
		.pixels     (pixels_q),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {6'b0, res.image_end, res.row_end,
	                  res.pix.a, res.pix.b, res.pix.g, res.pix.r};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

`default_nettype wire

>>> sv/qoid_chk.sv
`default_nettype none

module qoid_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [qoid_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input wire logic [1:0]                          m_tuser,
	input wire logic                                m_tlast
);
	import qoid_pkg::*;

	// hold a stalled transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled result changed");

	// a status result closes its byte and carries no pixel
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_PIXEL |-> m_tlast && m_tdata == '0)
		else $error("status result malformed");

	// the last pixel of the image ends the byte's results
	a_img_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PIXEL && m_tdata[33] |-> m_tlast)
		else $error("image end without last");

endmodule

bind qoi_image_decoder_core qoid_chk u_qoid_chk (.*);

`default_nettype wire

>>> test/qoi_checker.sv
module qoi_checker
	import qoid_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                   s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic [1:0]             m_tuser,
	input  wire logic                   m_tlast,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic                   cfg_index,
	input  wire logic [PIX_W-1:0]       cfg_data,
	output int                          errors,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_PIXELS = 1'b1;

	typedef enum logic [1:0] {PEND_NONE, PEND_RGB, PEND_RGBA, PEND_LUMA} pend_e;

	pix_t             palette [INDEX_ENTRIES];
	pix_t             cur_pix;
	pend_e            pend;
	logic [2:0]       pend_left;
	logic [5:0]       luma_dg;
	logic [PIX_W-1:0] done_cnt;
	logic [COL_W-1:0] col;
	logic [3:0]       mark_cnt;
	logic             mark_bad;
	logic [COL_W-1:0] width_reg;
	logic [PIX_W-1:0] total_reg;
	result_t          pixel_q [$];

	function automatic logic [5:0] slot_of(input pix_t p);
		int h;
		h = 3 * int'(p.r) + 5 * int'(p.g) + 7 * int'(p.b) + 11 * int'(p.a);
		return h[5:0];
	endfunction

	task automatic clear_image();
		foreach (palette[i]) palette[i] = '0;
		cur_pix   = PIX_RESET;
		pend      = PEND_NONE;
		pend_left = '0;
		luma_dg   = '0;
		done_cnt  = '0;
		col       = '0;
		mark_cnt  = '0;
		mark_bad  = 1'b0;
	endtask

	// Drop the pixel once the image is complete.
	task automatic emit_pixel();
		logic [COL_W-1:0] nxt;
		logic             re;
		logic             ie;
		if (done_cnt < total_reg) begin
			nxt = col + 1'b1;
			re  = (nxt == width_reg);
			ie  = (done_cnt + 1'b1 == total_reg);
			pixel_q.push_back('{kind: KIND_PIXEL, pix: cur_pix, row_end: re,
				image_end: ie, last: 1'b0});
			col      = re ? '0 : nxt;
			done_cnt = done_cnt + 1'b1;
		end
	endtask

	task automatic commit_pixel();
		palette[slot_of(cur_pix)] = cur_pix;
		emit_pixel();
	endtask

	task automatic decode_byte(input logic [7:0] b);
		pix_t       p;
		logic [7:0] dg;
		int         pos;
		p = cur_pix;
		case (pend)
			PEND_RGB, PEND_RGBA: begin
				pos = ((pend == PEND_RGB) ? 3 : 4) - int'(pend_left);
				case (pos)
					0: cur_pix.r = b;
					1: cur_pix.g = b;
					2: cur_pix.b = b;
					default: cur_pix.a = b;
				endcase
				pend_left = pend_left - 1'b1;
				if (pend_left == 0) begin
					pend = PEND_NONE;
					commit_pixel();
				end
			end
			PEND_LUMA: begin
				dg = {2'b00, luma_dg} - 8'd32;
				cur_pix.r = p.r + dg + b[7:4] - 8'd8;
				cur_pix.g = p.g + dg;
				cur_pix.b = p.b + dg + b[3:0] - 8'd8;
				pend      = PEND_NONE;
				pend_left = '0;
				commit_pixel();
			end
			default: begin
				if (b == TAG_RGB) begin
					pend      = PEND_RGB;
					pend_left = 3'd3;
				end else if (b == TAG_RGBA) begin
					pend      = PEND_RGBA;
					pend_left = 3'd4;
				end else begin
					case (b[7:6])
						TAG2_INDEX: begin
							cur_pix = palette[b[5:0]];
							commit_pixel();
						end
						TAG2_DIFF: begin
							cur_pix.r = p.r + b[5:4] - 8'd2;
							cur_pix.g = p.g + b[3:2] - 8'd2;
							cur_pix.b = p.b + b[1:0] - 8'd2;
							commit_pixel();
						end
						TAG2_LUMA: begin
							pend      = PEND_LUMA;
							pend_left = 3'd1;
							luma_dg   = b[5:0];
						end
						default: begin
							// run: index gets the repeated pixel once
							palette[slot_of(cur_pix)] = cur_pix;
							repeat (int'(b[5:0]) + 1) emit_pixel();
						end
					endcase
				end
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		int         n0;
		logic [7:0] mark_byte;
		result_t    got;
		result_t    want_r;
		if (!arst_n) begin
			errors    = 0;
			width_reg = COL_W'(1);
			total_reg = PIX_W'(1);
			clear_image();
			pixel_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					width_reg = cfg_data[COL_W-1:0];
				else if (cfg_index == REG_IMAGE_PIXELS)
					total_reg = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					clear_image();
				end else begin
					n0 = pixel_q.size();
					if (done_cnt < total_reg) begin
						decode_byte(s_tdata);
					end else if (mark_cnt < MARK_LEN) begin
						mark_byte = (mark_cnt == MARK_LEN - 1) ? 8'd1 : 8'd0;
						if (s_tdata != mark_byte)
							mark_bad = 1'b1;
						mark_cnt = mark_cnt + 1'b1;
						if (mark_cnt == MARK_LEN)
							pixel_q.push_back('{kind: mark_bad ? KIND_MARK_BAD : KIND_MARK_OK,
								pix: '0, row_end: 1'b0, image_end: 1'b0, last: 1'b0});
					end
					if (pixel_q.size() > n0)
						pixel_q[pixel_q.size() - 1].last = 1'b1;
				end
			end
			if (m_tvalid && m_tready) begin
				got.kind      = m_tuser;
				got.pix.r     = m_tdata[7:0];
				got.pix.g     = m_tdata[15:8];
				got.pix.b     = m_tdata[23:16];
				got.pix.a     = m_tdata[31:24];
				got.row_end   = m_tdata[32];
				got.image_end = m_tdata[33];
				got.last      = m_tlast;
				if (pixel_q.size() == 0) begin
					flag_mismatch($sformatf("kind %0d pixel %h arrived with nothing expected",
						got.kind, got.pix));
				end else begin
					want_r = pixel_q.pop_front();
					if (got !== want_r)
						flag_mismatch($sformatf({"kind %0d/%0d pixel %h/%h row_end %b/%b ",
							"image_end %b/%b last %b/%b (got/expected)"},
							got.kind, want_r.kind, got.pix, want_r.pix,
							got.row_end, want_r.row_end, got.image_end, want_r.image_end,
							got.last, want_r.last));
				end
			end
		end
		outstanding <= pixel_q.size();
	end

endmodule

>>> test/tb_qoi_image_decoder_core.sv
module tb_qoi_image_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;
	import qoid_pkg::*;

	localparam logic       REG_IMAGE_WIDTH  = 1'b0;
	localparam logic       REG_IMAGE_PIXELS = 1'b1;
	localparam logic       CMD_DATA         = 1'b0;
	localparam logic       CMD_START        = 1'b1;
	localparam logic [1:0] TAG2_RUN         = 2'b11;
	localparam int         SETTLE_CYCLES    = 12;   // queue depth plus index read latency, padded
	localparam int         HOLD_CYCLES      = 300;
	localparam logic [PIX_W-1:0] PIXELS_TOP = 30'd1073676289;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_index = 1'b0;
	logic [PIX_W-1:0]       cfg_data  = '0;

	int   errors;
	int   outstanding;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   data_items     = 0;
	int   hold_left      = 0;
	logic hold_req       = 1'b0;
	logic hold_taken     = 1'b0;

	// Opening image: every op with extreme operands, a run cut short by the
	// pixel count, then a clean end marker.
	logic [7:0] opening_bytes [26] = '{
		8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F,   // RGBA
		8'hFE, 8'hFF, 8'h00, 8'hAA,          // RGB
		8'h40, 8'h7F,                        // DIFF, lowest and highest deltas
		8'h80, 8'h00, 8'hBF, 8'hFF,          // LUMA, lowest and highest deltas
		8'h00,                               // INDEX
		8'hC0, 8'hFD,                        // RUN of 1, RUN of 62 (mostly dropped)
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
	};

	always #2 clk = ~clk;

	qoi_image_decoder_core dut (.*);

	qoi_checker chk (.*);

	// Receiver: random stalls, plus one long hold-off so the input queue backs up.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one input transaction and hold it until the block takes it.
	// Valid stays high on return; the next send or settle decides what follows.
	task automatic send(input logic cmd, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tuser  <= 1'($urandom);
			s_tdata  <= 8'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_DATA)
			data_items++;
	endtask

	// Write the selected registers back to back; valid stays high between them.
	task automatic write_regs(input bit do_w, input logic [COL_W-1:0] w,
			input bit do_n, input logic [PIX_W-1:0] n);
		if (do_w) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data  <= PIX_W'(w);
			do @(posedge clk); while (!cfg_ready);
		end
		if (do_n) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_IMAGE_PIXELS;
			cfg_data  <= n;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait until every expected result has come out, then give
	// bytes that produce nothing (start, marker, operands) time to drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One complete chunk with random content; left counts pixels still owed.
	task automatic send_op(inout int left);
		int n;
		case ($urandom_range(9))
			0: begin
				send(CMD_DATA, TAG_RGB);
				repeat (3) send(CMD_DATA, 8'($urandom));
				left--;
			end
			1: begin
				send(CMD_DATA, TAG_RGBA);
				repeat (4) send(CMD_DATA, 8'($urandom));
				left--;
			end
			2, 3: begin
				send(CMD_DATA, {TAG2_INDEX, 6'($urandom)});
				left--;
			end
			4, 5: begin
				send(CMD_DATA, {TAG2_DIFF, 6'($urandom)});
				left--;
			end
			6: begin
				send(CMD_DATA, {TAG2_LUMA, 6'($urandom)});
				send(CMD_DATA, 8'($urandom));
				left--;
			end
			default: begin
				// With fewer than 62 pixels owed, fit the run to the image half the time; else it may overshoot.
				if (left > 0 && left < 62 && $urandom_range(1) == 0)
					n = $urandom_range(1, left);
				else
					n = $urandom_range(1, 62);
				send(CMD_DATA, {TAG2_RUN, 6'(n - 1)});
				left -= n;
			end
		endcase
	endtask

	// One image: configure, start, chunks, end marker and stray trailing bytes.
	// shrink lowers the pixel count half way through; cut abandons the image
	// inside an RGB chunk.
	task automatic run_image(input logic [COL_W-1:0] w, input logic [PIX_W-1:0] total,
			input bit shrink, input bit cut);
		int         left;
		int         ops;
		int         max_ops;
		int         stop_at;
		int         produced;
		bit         bad;
		int         bad_pos;
		logic [7:0] b;
		settle();
		write_regs(1'b1, w, 1'b1, total);
		send(CMD_START, 8'($urandom));
		if (total > 30'd200) begin
			left    = 1000000;
			max_ops = 20;
		end else begin
			left    = int'(total);
			max_ops = cut ? 3 : 100;
		end
		stop_at = shrink ? int'(total) / 2 : 0;
		ops     = 0;
		while (left > stop_at && ops < max_ops) begin
			send_op(left);
			ops++;
		end
		if (cut) begin
			send(CMD_DATA, TAG_RGB);
			send(CMD_DATA, 8'($urandom));
			return;
		end
		if (shrink) begin
			produced = int'(total) - ((left > 0) ? left : 0);
			settle();
			write_regs(1'b0, w, 1'b1, PIX_W'($urandom_range(0, produced)));
		end else if (left > 0) begin
			return;
		end
		bad     = ($urandom_range(6) == 0);
		bad_pos = $urandom_range(MARK_LEN - 1);
		for (int i = 0; i < MARK_LEN; i++) begin
			b = (i == MARK_LEN - 1) ? 8'd1 : 8'd0;
			if (bad && i == bad_pos)
				b ^= 8'($urandom_range(1, 255));
			send(CMD_DATA, b);
		end
		repeat ($urandom_range(2)) send(CMD_DATA, 8'($urandom));
	endtask

	initial begin
		int               img;
		int               sel;
		logic [COL_W-1:0] w;
		logic [PIX_W-1:0] total;
		bit               shrink;
		bit               cut;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: width 4 against 11 pixels, so row and image ends disagree.
		write_regs(1'b1, 15'd4, 1'b1, 30'd11);
		send(CMD_START, 8'hA5);
		foreach (opening_bytes[i]) send(CMD_DATA, opening_bytes[i]);

		// Random images in four idling phases: none but the one long receiver hold-off,
		// sender gaps, receiver stalls, light both.
		img = 0;
		for (int phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
					hold_req       <= 1'b1;
				end
				1: begin
					send_idle_pct  <= 79;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 79;
				end
				default: begin
					send_idle_pct  <= 10;
					recv_stall_pct <= 10;
				end
			endcase
			while (data_items < 26 + 30 * (phase + 1)) begin
				img++;
				sel = $urandom_range(9);
				if (sel < 6)
					w = 15'($urandom_range(1, 8));
				else if (sel == 6)
					w = 15'($urandom_range(1, 40));
				else if (sel == 7)
					w = 15'h7FFF;
				else if (sel == 8)
					w = '0;
				else
					w = 15'd1;
				sel = $urandom_range(9);
				if (sel < 6)
					total = (w != 0 && w <= 8) ? PIX_W'(w * $urandom_range(1, 5))
						: PIX_W'($urandom_range(1, 40));
				else if (sel == 6)
					total = PIX_W'($urandom_range(1, 48));
				else if (sel == 7)
					total = PIXELS_TOP;
				else if (sel == 8)
					total = '1;
				else
					total = '0;
				shrink = (total != 0 && total <= 48 && $urandom_range(9) == 0);
				cut    = ($urandom_range(9) == 0);
				// Force the corner cases early so every seed sees them.
				case (img)
					1: begin
						w      = 15'd8;
						total  = 30'd40;
						shrink = 1'b0;
						cut    = 1'b0;
					end
					2: begin
						total  = '0;
						shrink = 1'b0;
						cut    = 1'b0;
					end
					3: begin
						w     = '0;
						total = 30'd20;
						cut   = 1'b0;
					end
					4: begin
						total  = 30'd20;
						shrink = 1'b1;
						cut    = 1'b0;
					end
					5: begin
						shrink = 1'b0;
						cut    = 1'b1;
					end
					default: ;
				endcase
				run_image(w, total, shrink, cut);
			end
		end

		settle();
		if (errors == 0 && outstanding == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> sim.f
sv/qoid_pkg.sv
sv/qoid_front.sv
sv/qoid_back.sv
sv/qoi_image_decoder_core.sv
sv/qoid_chk.sv
test/qoi_checker.sv
test/tb_qoi_image_decoder_core.sv
